// ===== sv/inm_pkg.sv =====
// ----------------------------------------------------------------------------
// inm_pkg: shared types and constants of the If-None-Match matcher
// Parse mode codes, character codes and the tag configuration bundle.
// ----------------------------------------------------------------------------
`default_nettype none

package inm_pkg;

  // Widest tag the configuration registers can hold, in characters.
  localparam int unsigned MAX_TAG_CHARS = 16;
  localparam int unsigned LEN_W         = 5;

  // Parse modes.
  localparam logic [2:0] MODE_BETWEEN  = 3'd0;
  localparam logic [2:0] MODE_AFTER_W  = 3'd1;
  localparam logic [2:0] MODE_AFTER_SL = 3'd2;
  localparam logic [2:0] MODE_IN_TAG   = 3'd3;
  localparam logic [2:0] MODE_DECIDED  = 3'd4;

  // Characters of interest.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // Register indexes.
  localparam logic [1:0] REG_CHARS_LOW  = 2'd0;
  localparam logic [1:0] REG_CHARS_HIGH = 2'd1;
  localparam logic [1:0] REG_TAG_LENGTH = 2'd2;

  typedef struct packed {
    logic [8*MAX_TAG_CHARS-1:0] chars;
    logic [LEN_W-1:0]           length;
  } inm_tag_cfg_t;

endpackage

`default_nettype wire

// ===== sv/inm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// inm_cfg_regs: configuration registers of the If-None-Match matcher
// APB-style write and read of the wanted tag characters and its length.
// ----------------------------------------------------------------------------
`default_nettype none

module inm_cfg_regs
  import inm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output inm_tag_cfg_t     tag_cfg
);

  logic [63:0]      chars_low_r;
  logic [63:0]      chars_high_r;
  logic [LEN_W-1:0] length_r;
  logic [1:0]       reg_idx;
  logic             wr_en;

  // Registers sit on 8-byte boundaries.
  assign reg_idx = paddr[4:3];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_low_r  <= '0;
      chars_high_r <= '0;
      length_r     <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CHARS_LOW:  chars_low_r  <= pwdata;
        REG_CHARS_HIGH: chars_high_r <= pwdata;
        REG_TAG_LENGTH: length_r     <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHARS_LOW:  prdata = chars_low_r;
      REG_CHARS_HIGH: prdata = chars_high_r;
      REG_TAG_LENGTH: prdata = {{(64-LEN_W){1'b0}}, length_r};
      default:        prdata = '0;
    endcase
  end

  assign tag_cfg.chars  = {chars_high_r, chars_low_r};
  assign tag_cfg.length = length_r;

endmodule

`default_nettype wire

// ===== sv/inm_parse.sv =====
// ----------------------------------------------------------------------------
// inm_parse: header parse state and per-byte decision logic
// Holds the parse mode, tag position and answer, updated once per word.
// ----------------------------------------------------------------------------
`default_nettype none

module inm_parse
  import inm_pkg::*;
#(
  parameter int unsigned TAG_CHARS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         step,
  input  wire logic [7:0]   hdr_byte,
  input  wire logic         hdr_last,
  input  wire inm_tag_cfg_t tag_cfg,
  output logic              res_match
);

  localparam int unsigned CW = $clog2(TAG_CHARS + 1);
  localparam int unsigned IW = (TAG_CHARS > 1) ? $clog2(TAG_CHARS) : 1;
  localparam logic [CW-1:0] POS_LIMIT = CW'(TAG_CHARS);

  logic [2:0]    mode_r,  mode_nxt,  mode_c;
  logic [CW-1:0] pos_r,   pos_nxt,   pos_c;
  logic          diff_r,  diff_nxt,  diff_c;
  logic          ans_r,   ans_nxt,   ans_c;
  logic [7:0]    tag_bytes [TAG_CHARS];
  logic [7:0]    want;

  for (genvar k = 0; k < TAG_CHARS; k++) begin : g_bytes
    assign tag_bytes[k] = tag_cfg.chars[8*k +: 8];
  end

  assign want = tag_bytes[pos_r[IW-1:0]];

  always_comb begin
    mode_c = mode_r;
    pos_c  = pos_r;
    diff_c = diff_r;
    ans_c  = ans_r;
    if (mode_r != MODE_DECIDED) begin
      if (hdr_byte == CH_NUL) begin
        mode_c = MODE_DECIDED;
        ans_c  = 1'b0;
      end else begin
        case (mode_r)
          MODE_BETWEEN: begin
            if (hdr_byte inside {CH_SPACE, CH_TAB, CH_COMMA}) begin
              mode_c = MODE_BETWEEN;
            end else if (hdr_byte == CH_STAR) begin
              mode_c = MODE_DECIDED;
              ans_c  = 1'b1;
            end else if (hdr_byte == CH_W) begin
              mode_c = MODE_AFTER_W;
            end else if (hdr_byte == CH_QUOTE) begin
              mode_c = MODE_IN_TAG;
              pos_c  = '0;
              diff_c = 1'b0;
            end else begin
              mode_c = MODE_DECIDED;
              ans_c  = 1'b0;
            end
          end
          MODE_AFTER_W: begin
            if (hdr_byte == CH_SLASH) begin
              mode_c = MODE_AFTER_SL;
            end else begin
              mode_c = MODE_DECIDED;
              ans_c  = 1'b0;
            end
          end
          MODE_AFTER_SL: begin
            if (hdr_byte == CH_QUOTE) begin
              mode_c = MODE_IN_TAG;
              pos_c  = '0;
              diff_c = 1'b0;
            end else begin
              mode_c = MODE_DECIDED;
              ans_c  = 1'b0;
            end
          end
          MODE_IN_TAG: begin
            if (hdr_byte == CH_QUOTE) begin
              if ((6'(pos_r) == 6'(tag_cfg.length)) && !diff_r) begin
                mode_c = MODE_DECIDED;
                ans_c  = 1'b1;
              end else begin
                mode_c = MODE_BETWEEN;
              end
            end else if (pos_r < POS_LIMIT) begin
              if (hdr_byte != want) begin
                diff_c = 1'b1;
              end
              pos_c = pos_r + 1'b1;
            end else begin
              diff_c = 1'b1;
            end
          end
          default: begin
            mode_c = MODE_DECIDED;
            ans_c  = 1'b0;
          end
        endcase
      end
    end
  end

  assign res_match = (mode_c == MODE_DECIDED) && ans_c;

  // The last byte of a header returns the parser to its idle state.
  always_comb begin
    if (hdr_last) begin
      mode_nxt = MODE_BETWEEN;
      pos_nxt  = '0;
      diff_nxt = 1'b0;
      ans_nxt  = 1'b0;
    end else begin
      mode_nxt = mode_c;
      pos_nxt  = pos_c;
      diff_nxt = diff_c;
      ans_nxt  = ans_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BETWEEN;
      pos_r  <= '0;
      diff_r <= 1'b0;
      ans_r  <= 1'b0;
    end else if (step) begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      diff_r <= diff_nxt;
      ans_r  <= ans_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (step && hdr_last) |=> (mode_r == MODE_BETWEEN) && (pos_r == '0) && !ans_r)
    else $error("parse state not cleared after last byte");

  a_ans_only_decided: assert property (@(posedge clk) disable iff (!rst_n)
    ans_r |-> (mode_r == MODE_DECIDED))
    else $error("answer set outside decided mode");

endmodule

`default_nettype wire

// ===== sv/etag_if_none_match_matcher.sv =====
// ----------------------------------------------------------------------------
// etag_if_none_match_matcher: weak ETag compare of an If-None-Match header
// Path: a header byte is registered, then parsed; the match word is loaded
//   into the result register at the edge where the parser takes the last
//   byte, which a held result can delay, and out_valid comes straight from it.
// Throughput: one header byte per cycle while out_stall does not hold a result;
//   the parse state update is the only loop, closed through the byte compare.
// Reset: synchronous, active low; clears the pipeline valids, the parse state
//   and all configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module etag_if_none_match_matcher
  import inm_pkg::*;
#(
  parameter int unsigned TAG_CHARS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Header byte stream.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_header_byte,
  input  wire logic        in_last,
  // Match result, one word per header.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_match,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic      [63:0] prdata,
  output logic             pready
);

  inm_tag_cfg_t tag_cfg;

  // Input register stage. A word sits here until the parser takes it.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;

  // Result register.
  logic       out_valid_r;
  logic       out_match_r;

  logic       can_move;
  logic       s1_adv;
  logic       in_accept;
  logic       par_match;

  assign pready = 1'b1;

  inm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .tag_cfg (tag_cfg)
  );

  // The parser may consume the registered word whenever the result register
  // is free or is being emptied this cycle. Non-last words could go ahead
  // regardless, but holding them keeps the control to one condition.
  assign can_move  = !out_valid_r || !out_stall;
  assign s1_adv    = s1_valid_r && can_move;
  assign in_stall  = s1_valid_r && !can_move;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_byte_r <= in_header_byte;
      s1_last_r <= in_last;
    end
  end

  inm_parse #(
    .TAG_CHARS (TAG_CHARS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_adv),
    .hdr_byte  (s1_byte_r),
    .hdr_last  (s1_last_r),
    .tag_cfg   (tag_cfg),
    .res_match (par_match)
  );

  // Only the last byte of a header produces a result word.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_last_r) begin
      out_match_r <= par_match;
    end
  end

  assign out_valid = out_valid_r;
  assign out_match = out_match_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall && s1_valid_r) |-> !s1_adv)
    else $error("pending result would be overwritten");

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled without a held word");

endmodule

`default_nettype wire

// ===== sim/inm_match_checker.sv =====
// ----------------------------------------------------------------------------
// inm_match_checker: prediction and compare for the If-None-Match matcher
// Watches the header byte stream, the match word stream and the register
// port, keeps its own copy of the parse state, and compares every match word
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module inm_match_checker
  import inm_pkg::*;
#(
  parameter int unsigned TAG_CHARS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_header_byte,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_match,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  input  logic        pready,
  output int          mismatch_count,
  output int          words_pending
);

  logic [63:0]      want_low;
  logic [63:0]      want_high;
  logic [LEN_W-1:0] want_len;

  logic [2:0]       mode;
  logic [LEN_W-1:0] tag_pos;
  logic             tag_bad;
  logic             answer;
  logic             oldest_match;

  logic expected_match_q[$];

  task automatic settle(input logic ans);
    answer = ans;
    mode   = MODE_DECIDED;
  endtask

  // Advances the parse state by one header byte.
  task automatic parse_header_byte(input logic [7:0] b);
    logic [8*MAX_TAG_CHARS-1:0] chars;
    chars = {want_high, want_low};
    if (mode != MODE_DECIDED) begin
      if (b == CH_NUL) begin
        settle(1'b0);
      end else begin
        case (mode)
          MODE_BETWEEN: begin
            if (b == CH_SPACE || b == CH_TAB || b == CH_COMMA) begin
              // Separators between tags are skipped.
            end else if (b == CH_STAR) begin
              settle(1'b1);
            end else if (b == CH_W) begin
              mode = MODE_AFTER_W;
            end else if (b == CH_QUOTE) begin
              mode    = MODE_IN_TAG;
              tag_pos = '0;
              tag_bad = 1'b0;
            end else begin
              settle(1'b0);
            end
          end
          MODE_AFTER_W: begin
            if (b == CH_SLASH) mode = MODE_AFTER_SL;
            else settle(1'b0);
          end
          MODE_AFTER_SL: begin
            if (b == CH_QUOTE) begin
              mode    = MODE_IN_TAG;
              tag_pos = '0;
              tag_bad = 1'b0;
            end else begin
              settle(1'b0);
            end
          end
          MODE_IN_TAG: begin
            if (b == CH_QUOTE) begin
              if (tag_pos == want_len && !tag_bad) settle(1'b1);
              else mode = MODE_BETWEEN;
            end else if (tag_pos < TAG_CHARS) begin
              if (b != chars[8*tag_pos +: 8]) tag_bad = 1'b1;
              tag_pos = tag_pos + 1'b1;
            end else begin
              // Characters past the widest tag can never match.
              tag_bad = 1'b1;
            end
          end
          default: settle(1'b0);
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      want_low       = '0;
      want_high      = '0;
      want_len       = '0;
      mode           = MODE_BETWEEN;
      tag_pos        = '0;
      tag_bad        = 1'b0;
      answer         = 1'b0;
      mismatch_count = 0;
      expected_match_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_CHARS_LOW:  want_low  = pwdata;
          REG_CHARS_HIGH: want_high = pwdata;
          REG_TAG_LENGTH: want_len  = pwdata[LEN_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall) begin
        if (expected_match_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: match word with none expected: expected none, actual %0b",
                   $time, out_match);
        end else begin
          oldest_match = expected_match_q.pop_front();
          if (out_match !== oldest_match) begin
            mismatch_count++;
            $display("%0t: match mismatch: expected %0b, actual %0b",
                     $time, oldest_match, out_match);
          end
        end
      end

      if (in_valid && !in_stall) begin
        parse_header_byte(in_header_byte);
        if (in_last) begin
          expected_match_q.push_back(mode == MODE_DECIDED && answer);
          mode    = MODE_BETWEEN;
          tag_pos = '0;
          tag_bad = 1'b0;
          answer  = 1'b0;
        end
      end
    end
    words_pending <= expected_match_q.size();
  end

endmodule

// ===== sim/tb_etag_if_none_match_matcher.sv =====
// ----------------------------------------------------------------------------
// tb_etag_if_none_match_matcher: stimulus and verdict for the matcher
// Feeds directed and randomly built If-None-Match headers through the byte
// stream under several tag settings, with random gaps and stalls on both
// sides, and reports the outcome from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_etag_if_none_match_matcher;
  import inm_pkg::*;

  // Register index that decodes to nothing; writes there must be ignored.
  localparam logic [1:0] REG_UNUSED = 2'd3;

  localparam int PHASES      = 9;
  localparam int PHASE_BYTES = 80;
  localparam int HOLD_CYCLES = 80;

  typedef enum {EL_MATCH, EL_NEAR, EL_RANDOM, EL_STAR, EL_BROKEN} element_kind_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  wire         in_stall;
  logic [7:0]  in_header_byte;
  logic        in_last;
  wire         out_valid;
  wire         out_stall;
  wire         out_match;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  wire  [63:0] prdata;
  wire         pready;

  // The receiver stall is the OR of the per-word random stall and the long
  // hold, each owned by its own process.
  logic rx_stall;
  logic rx_hold;
  assign out_stall = rx_stall | rx_hold;

  bit gaps_on;
  bit rx_idle_on;
  bit hold_go;

  // Copy of the programmed tag, used only to build matching and near tags.
  logic [63:0] cfg_low;
  logic [63:0] cfg_high;
  logic [4:0]  cfg_len;

  logic [7:0] hdr[$];
  int         mismatch_count;
  int         words_pending;

  etag_if_none_match_matcher #(.TAG_CHARS(16)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_header_byte (in_header_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_match      (out_match),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  inm_match_checker #(.TAG_CHARS(16)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_header_byte (in_header_byte),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_match      (out_match),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop in case the block hangs or a word never shows up.
  initial begin
    #(12 * 400000);
    $display("etag_if_none_match_matcher verification failed");
    $finish;
  end

  // A printable tag character other than the quote, so that a configured tag
  // can be sent back intact inside quotes.
  function automatic logic [7:0] rand_tag_char();
    logic [7:0] c;
    do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [63:0] rand_tag_word();
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = rand_tag_char();
    return w;
  endfunction

  function automatic logic [7:0] rand_separator();
    case ($urandom_range(0, 2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_COMMA;
    endcase
  endfunction

  // Offers one word on the header stream and returns at the edge where it is
  // taken. The idle gap before it is drawn per word.
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_header_byte <= b;
    in_last        <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_header();
    for (int i = 0; i < hdr.size(); i++) send_byte(hdr[i], i == hdr.size() - 1);
    hdr.delete();
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) hdr.push_back(s[i]);
  endtask

  // Lowers valid in the step where the last word was taken, then waits until
  // every predicted match word has come back and lets the two-stage pipeline
  // go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (words_pending != 0);
    repeat (6) @(posedge clk);
  endtask

  // One register write: setup cycle, access cycle, then an idle cycle so that
  // back-to-back writes never assign psel twice in one step.
  task automatic cfg_write(input logic [1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_CHARS_LOW:  cfg_low  = value;
      REG_CHARS_HIGH: cfg_high = value;
      REG_TAG_LENGTH: cfg_len  = value[4:0];
      default: ;
    endcase
  endtask

  // Builds one random header in hdr. Most elements are quoted tags that match
  // the programmed tag or miss it by one character, so the parser spends most
  // of its time deep inside tags; the rest are wildcards, malformed elements,
  // random tags and truncated headers.
  task automatic build_header();
    int            n_el;
    int            len;
    int            pick;
    int            keep;
    int            idx;
    element_kind_t kind;
    logic [7:0]    body[$];
    logic [127:0]  chars;
    chars = {cfg_high, cfg_low};
    hdr.delete();
    n_el = $urandom_range(0, 3);
    for (int k = 0; k < n_el; k++) begin
      repeat ($urandom_range(0, 2)) hdr.push_back(rand_separator());
      pick = $urandom_range(0, 99);
      if (pick < 40)      kind = EL_MATCH;
      else if (pick < 65) kind = EL_NEAR;
      else if (pick < 80) kind = EL_RANDOM;
      else if (pick < 85) kind = EL_STAR;
      else                kind = EL_BROKEN;
      body.delete();
      case (kind)
        EL_MATCH, EL_NEAR: begin
          // A length above the widest tag is still sent, padded out with
          // printable characters, so it runs past the compare window.
          len = (cfg_len > 20) ? 20 : cfg_len;
          for (int i = 0; i < len; i++)
            body.push_back(i < 16 ? chars[8*i +: 8] : rand_tag_char());
          if (kind == EL_NEAR) begin
            case ($urandom_range(0, 2))
              0: begin
                if (body.size() > 0) begin
                  idx = $urandom_range(0, body.size() - 1);
                  body[idx] = body[idx] ^ (8'h01 << $urandom_range(0, 7));
                end else begin
                  body.push_back(rand_tag_char());
                end
              end
              1: begin
                if (body.size() > 0) void'(body.pop_back());
                else body.push_back(rand_tag_char());
              end
              default: body.push_back(rand_tag_char());
            endcase
          end
        end
        EL_RANDOM: begin
          len = $urandom_range(0, 24);
          for (int i = 0; i < len; i++) body.push_back(8'($urandom_range(0, 255)));
        end
        default: ;
      endcase
      case (kind)
        EL_STAR: hdr.push_back(CH_STAR);
        EL_BROKEN: begin
          case ($urandom_range(0, 3))
            0: begin
              hdr.push_back(CH_W);
              hdr.push_back(8'($urandom_range(0, 255)));
            end
            1: begin
              hdr.push_back(CH_W);
              hdr.push_back(CH_SLASH);
              hdr.push_back(8'($urandom_range(0, 255)));
            end
            2: hdr.push_back(8'($urandom_range(0, 255)));
            default: hdr.push_back(CH_NUL);
          endcase
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            hdr.push_back(CH_W);
            hdr.push_back(CH_SLASH);
          end
          hdr.push_back(CH_QUOTE);
          foreach (body[i]) hdr.push_back(body[i]);
          hdr.push_back(CH_QUOTE);
        end
      endcase
    end
    repeat ($urandom_range(0, 1)) hdr.push_back(rand_separator());
    // Now and then the header is cut short, leaving a tag or a prefix open.
    if ($urandom_range(0, 9) == 0 && hdr.size() > 1) begin
      keep = $urandom_range(1, hdr.size() - 1);
      while (hdr.size() > keep) void'(hdr.pop_back());
    end
    // A header of separators only stands for an empty list.
    if (hdr.size() == 0) hdr.push_back(rand_separator());
  endtask

  // Receiver: draws a random stall, when enabled, ahead of every match word.
  initial begin
    int n;
    rx_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = rx_idle_on ? $urandom_range(0, 4) : 0;
      if (n > 0) begin
        rx_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      rx_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  // Long hold on the result side, counted here, while the sender keeps
  // streaming so that the pipeline fills and in_stall has to rise.
  initial begin
    rx_hold <= 1'b0;
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  initial begin
    int phase_bytes;
    gaps_on    = 1'b1;
    rx_idle_on = 1'b1;
    hold_go    = 1'b0;
    cfg_low    = '0;
    cfg_high   = '0;
    cfg_len    = '0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_header_byte <= '0;
    in_last        <= 1'b0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed headers against the reset tag, which is empty. A wildcard and
    // an empty quoted tag both match; the rest covers skipped separators, the
    // weak prefix, a W without its slash (also before a zero byte), a weak
    // prefix without a quote, a stray 8'hFF, an open tag, a zero byte ahead
    // of a wildcard, and a list of separators only.
    push_text("*");
    send_header();
    push_text("\"\"");
    send_header();
    push_text(" \t,\"\"");
    send_header();
    push_text("W/\"\"");
    send_header();
    push_text("Wx");
    send_header();
    push_text("W");
    hdr.push_back(CH_NUL);
    send_header();
    push_text("W/x");
    send_header();
    hdr.push_back(8'hFF);
    send_header();
    push_text("\"a");
    send_header();
    hdr.push_back(CH_NUL);
    push_text("*");
    send_header();
    push_text(" ");
    send_header();

    // Random phases, each under its own tag setting. Every phase starts only
    // once all match words of the one before have come back.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin
          cfg_write(REG_CHARS_LOW, rand_tag_word());
          cfg_write(REG_CHARS_HIGH, rand_tag_word());
          cfg_write(REG_TAG_LENGTH, 64'd16);
          cfg_write(REG_UNUSED, {$urandom, $urandom});
        end
        1: cfg_write(REG_TAG_LENGTH, 64'd0);
        2: begin
          // A length above the widest tag: only wildcards can match.
          cfg_write(REG_CHARS_LOW, rand_tag_word());
          cfg_write(REG_CHARS_HIGH, rand_tag_word());
          cfg_write(REG_TAG_LENGTH, 64'd31);
        end
        3: begin
          cfg_write(REG_CHARS_LOW, '1);
          cfg_write(REG_CHARS_HIGH, '1);
          cfg_write(REG_TAG_LENGTH, 64'd16);
        end
        4: begin
          cfg_write(REG_CHARS_LOW, rand_tag_word());
          cfg_write(REG_CHARS_HIGH, rand_tag_word());
          cfg_write(REG_TAG_LENGTH, 64'd17);
        end
        5: begin
          cfg_write(REG_CHARS_LOW, '0);
          cfg_write(REG_CHARS_HIGH, '0);
          cfg_write(REG_TAG_LENGTH, 64'd5);
        end
        default: begin
          cfg_write(REG_CHARS_LOW, rand_tag_word());
          cfg_write(REG_CHARS_HIGH, rand_tag_word());
          cfg_write(REG_TAG_LENGTH, 64'($urandom_range(1, 16)));
        end
      endcase
      gaps_on    = (p != 2 && p != 6);
      rx_idle_on = (p != 4 && p != 7);
      if (p == 2) hold_go = 1'b1;
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        build_header();
        phase_bytes += hdr.size();
        send_header();
      end
    end

    drain();
    if (mismatch_count == 0) begin
      $display("etag_if_none_match_matcher verification clean");
    end else begin
      $display("etag_if_none_match_matcher verification failed");
    end
    $finish;
  end

endmodule
